@@ hdl/eae_pkg.sv @@
`timescale 1ns / 1ps
package eae_pkg;
  localparam int TIME_BITS = 48;
  localparam int DUR_BITS = 36;
  localparam int FRAC_BITS = 16;
  localparam int LVL_W = FRAC_BITS + 1;
  localparam int GEN_W = 32;
  localparam int REL_W = TIME_BITS + 1;
  localparam logic [LVL_W-1:0] ONE_LEVEL = LVL_W'(1) << FRAC_BITS;

  localparam logic [2:0] REQ_SAMPLE  = 3'd0;
  localparam logic [2:0] REQ_TRIGGER = 3'd1;
  localparam logic [2:0] REQ_GATE    = 3'd2;
  localparam logic [2:0] REQ_PULSE   = 3'd3;
  localparam logic [2:0] REQ_RESET   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ORDER    = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_DECAY   = 3'd1;
  localparam logic [2:0] REG_RELEASE = 3'd2;
  localparam logic [2:0] REG_PULSE   = 3'd3;
  localparam logic [2:0] REG_SUSTAIN = 3'd4;
  localparam logic [2:0] REG_GEN     = 3'd5;

  typedef struct packed {
    logic [2:0]           req_type;
    logic [TIME_BITS-1:0] time_ticks;
    logic [LVL_W-1:0]     event_value;
    logic [GEN_W-1:0]     event_generation;
  } req_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [1:0]       status;
  } rsp_t;

  typedef struct packed {
    logic                start;
    logic [DUR_BITS-1:0] a;
    logic [LVL_W-1:0]    b;
    logic [DUR_BITS-1:0] c;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LVL_W-1:0] q;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_HELD,
    S_HDIV,
    S_HMUL,
    S_RMUL,
    S_RSTART,
    S_RDIV,
    S_DONE
  } state_t;
endpackage

@@ hdl/eae_div.sv @@
`timescale 1ns / 1ps
module eae_div (
  input  logic              clk,
  input  logic              rst,
  input  eae_pkg::div_req_t req,
  output eae_pkg::div_rsp_t rsp
);
  localparam int CW = $clog2(eae_pkg::LVL_W);
  localparam int RW = eae_pkg::DUR_BITS + 2;

  logic                         busy;
  logic                         done;
  logic [CW-1:0]                cnt;
  logic [eae_pkg::DUR_BITS-1:0] a, c, r;
  logic [eae_pkg::LVL_W-1:0]    b, q;
  logic [RW-1:0]                r2, r3, r4;
  logic                         n1, n2;
  logic [eae_pkg::DUR_BITS-1:0] r_next;
  logic [eae_pkg::LVL_W-1:0]    q_next;

  always_comb begin
    r2 = {1'b0, r, 1'b0} + (b[cnt] ? {2'b00, a} : RW'(0));
    n1 = (r2 >= {2'b00, c});
    r3 = n1 ? r2 - {2'b00, c} : r2;
    n2 = (r3 >= {2'b00, c});
    r4 = n2 ? r3 - {2'b00, c} : r3;
    r_next = r4[eae_pkg::DUR_BITS-1:0];
    q_next = {q[eae_pkg::LVL_W-2:0], 1'b0} + eae_pkg::LVL_W'(n1) + eae_pkg::LVL_W'(n2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(eae_pkg::LVL_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
      c <= req.c;
      r <= '0;
      q <= '0;
    end else if (busy) begin
      r <= r_next;
      q <= q_next;
    end
  end

  assign rsp.done = done;
  assign rsp.q    = q;
endmodule

@@ hdl/event_adsr_envelope.sv @@
`timescale 1ns / 1ps
// channel  signals                     beat when
// in       in_valid in_stall in_data   in_valid && !in_stall
// out      out_valid out_stall out_data out_valid && !out_stall
// cfg      psel penable pwrite paddr   psel && penable && pwrite && pready
//
// one item at a time; out_valid rises after the states DECODE and DONE when no
// level is needed, after DECODE, HELD, HMUL and DONE when the held level sits at
// sustain, and later with a division; the serial divider works in 17 steps, one quotient bit a cycle
// synchronous active-high reset; no clearing pass
// in_stall stays high while an item is at work or a result waits; the next
// input beat can be taken in the cycle after the result beat leaves
module event_adsr_envelope (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  eae_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output eae_pkg::rsp_t  out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [5:0]     paddr,
  input  logic [63:0]    pwdata,
  output logic [63:0]    prdata,
  output logic           pready
);
  localparam int TB = eae_pkg::TIME_BITS;
  localparam int DB = eae_pkg::DUR_BITS;
  localparam int LW = eae_pkg::LVL_W;
  localparam int RB = eae_pkg::REL_W;
  localparam int PW = 2 * LW;

  logic [DB-1:0]            attack_ticks, decay_ticks, release_ticks, pulse_ticks;
  logic [LW-1:0]            sustain_level;
  logic [eae_pkg::GEN_W-1:0] expected_generation;

  logic          started, released;
  logic [TB-1:0] start_time, last_event_time;
  logic [RB-1:0] release_time;
  logic [LW-1:0] release_level, amplitude;

  eae_pkg::state_t state, state_next;
  eae_pkg::req_t   item;
  logic [TB-1:0]   el;
  logic            goal_sample, dec_mode;
  logic [LW-1:0]   held, ar, item_level;
  logic [1:0]      item_status;

  eae_pkg::div_req_t dreq;
  eae_pkg::div_rsp_t drsp;

  eae_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // configuration
  logic [2:0] cfg_idx;
  logic       cfg_wr;
  assign cfg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks        <= '0;
      decay_ticks         <= '0;
      release_ticks       <= '0;
      pulse_ticks         <= '0;
      sustain_level       <= eae_pkg::ONE_LEVEL;
      expected_generation <= eae_pkg::GEN_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        eae_pkg::REG_ATTACK:  attack_ticks        <= pwdata[DB-1:0];
        eae_pkg::REG_DECAY:   decay_ticks         <= pwdata[DB-1:0];
        eae_pkg::REG_RELEASE: release_ticks       <= pwdata[DB-1:0];
        eae_pkg::REG_PULSE:   pulse_ticks         <= pwdata[DB-1:0];
        eae_pkg::REG_SUSTAIN: sustain_level       <= pwdata[LW-1:0];
        eae_pkg::REG_GEN:     expected_generation <= pwdata[eae_pkg::GEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      eae_pkg::REG_ATTACK:  prdata = 64'(attack_ticks);
      eae_pkg::REG_DECAY:   prdata = 64'(decay_ticks);
      eae_pkg::REG_RELEASE: prdata = 64'(release_ticks);
      eae_pkg::REG_PULSE:   prdata = 64'(pulse_ticks);
      eae_pkg::REG_SUSTAIN: prdata = 64'(sustain_level);
      eae_pkg::REG_GEN:     prdata = 64'(expected_generation);
      default:              prdata = '0;
    endcase
  end

  // decode of the held item
  logic          in_fire;
  logic          bad_kind, gen_bad, val_bad, t_early;
  logic          is_sample, is_gate_off, gate_off_do, in_release;
  logic [RB-1:0] t_ext, d;
  logic          rel_silent;
  logic [LW-1:0] sus;
  logic [TB-1:0] el_sample, el2;
  logic          in_attack, in_decay;

  assign in_fire = in_valid && !in_stall;

  always_comb begin
    bad_kind    = item.req_type > eae_pkg::REQ_RESET;
    gen_bad     = (item.event_generation == '0) ||
                  (item.event_generation != expected_generation);
    val_bad     = (item.req_type != eae_pkg::REQ_RESET) &&
                  (item.event_value > eae_pkg::ONE_LEVEL);
    t_early     = item.time_ticks < last_event_time;
    is_sample   = item.req_type == eae_pkg::REQ_SAMPLE;
    is_gate_off = (item.req_type == eae_pkg::REQ_GATE) && (item.event_value == '0);
    t_ext       = {1'b0, item.time_ticks};
    in_release  = released && (t_ext >= release_time);
    gate_off_do = started && !in_release;
    d           = t_ext - release_time;
    rel_silent  = (release_ticks == '0) || (d >= RB'(release_ticks));
    el_sample   = (item.time_ticks >= start_time) ? item.time_ticks - start_time : '0;
    sus         = (sustain_level > eae_pkg::ONE_LEVEL) ? eae_pkg::ONE_LEVEL : sustain_level;
    in_attack   = el < TB'(attack_ticks);
    el2         = el - TB'(attack_ticks);
    in_decay    = el2 < TB'(decay_ticks);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      eae_pkg::S_IDLE: if (in_fire) state_next = eae_pkg::S_DECODE;
      eae_pkg::S_DECODE: begin
        if (is_sample) begin
          if (t_early || !started) state_next = eae_pkg::S_DONE;
          else if (!in_release) state_next = eae_pkg::S_HELD;
          else if (rel_silent) state_next = eae_pkg::S_DONE;
          else state_next = eae_pkg::S_RMUL;
        end else if (bad_kind || gen_bad || val_bad || t_early) begin
          state_next = eae_pkg::S_DONE;
        end else if (is_gate_off) begin
          state_next = gate_off_do ? eae_pkg::S_HELD : eae_pkg::S_DONE;
        end else if (item.req_type == eae_pkg::REQ_PULSE) begin
          state_next = eae_pkg::S_HELD;
        end else begin
          state_next = eae_pkg::S_DONE;
        end
      end
      eae_pkg::S_HELD:
        state_next = (in_attack || in_decay) ? eae_pkg::S_HDIV : eae_pkg::S_HMUL;
      eae_pkg::S_HDIV:   if (drsp.done) state_next = eae_pkg::S_HMUL;
      eae_pkg::S_HMUL:   state_next = eae_pkg::S_DONE;
      eae_pkg::S_RMUL:   state_next = eae_pkg::S_RSTART;
      eae_pkg::S_RSTART: state_next = eae_pkg::S_RDIV;
      eae_pkg::S_RDIV:   if (drsp.done) state_next = eae_pkg::S_DONE;
      eae_pkg::S_DONE:   state_next = eae_pkg::S_IDLE;
      default:           state_next = eae_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall   = (state != eae_pkg::S_IDLE) || out_valid;
    dreq.start = 1'b0;
    dreq.a     = el[DB-1:0];
    dreq.b     = eae_pkg::ONE_LEVEL;
    dreq.c     = attack_ticks;
    unique case (state)
      eae_pkg::S_HELD: begin
        dreq.start = in_attack || in_decay;
        if (!in_attack) begin
          dreq.a = el2[DB-1:0];
          dreq.b = eae_pkg::ONE_LEVEL - sus;
          dreq.c = decay_ticks;
        end
      end
      eae_pkg::S_RSTART: begin
        dreq.start = 1'b1;
        dreq.a     = release_ticks - d[DB-1:0];
        dreq.b     = ar;
        dreq.c     = release_ticks;
      end
      default: ;
    endcase
  end

  logic [PW-1:0] prod;
  always_comb begin
    if (state == eae_pkg::S_RMUL) prod = PW'(amplitude) * PW'(release_level);
    else prod = PW'(amplitude) * PW'(held);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= eae_pkg::S_IDLE;
      out_valid       <= 1'b0;
      started         <= 1'b0;
      released        <= 1'b0;
      start_time      <= '0;
      release_time    <= '0;
      release_level   <= '0;
      amplitude       <= eae_pkg::ONE_LEVEL;
      last_event_time <= '0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        eae_pkg::S_DECODE: begin
          if (!is_sample && !(bad_kind || gen_bad || val_bad || t_early)) begin
            last_event_time <= item.time_ticks;
            if (item.req_type == eae_pkg::REQ_RESET) begin
              started       <= 1'b0;
              released      <= 1'b0;
              start_time    <= '0;
              release_time  <= '0;
              release_level <= '0;
              amplitude     <= eae_pkg::ONE_LEVEL;
            end else if (is_gate_off) begin
              if (gate_off_do) begin
                release_time <= t_ext;
                released     <= 1'b1;
              end
            end else begin
              started    <= 1'b1;
              start_time <= item.time_ticks;
              amplitude  <= item.event_value;
              released   <= item.req_type == eae_pkg::REQ_PULSE;
              if (item.req_type == eae_pkg::REQ_PULSE)
                release_time <= t_ext + RB'(pulse_ticks);
            end
          end
        end
        eae_pkg::S_HMUL: if (!goal_sample) release_level <= held;
        eae_pkg::S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      eae_pkg::S_IDLE: if (in_fire) item <= in_data;
      eae_pkg::S_DECODE: begin
        item_level  <= '0;
        goal_sample <= is_sample;
        if (is_sample) begin
          item_status <= t_early ? eae_pkg::ST_ORDER : eae_pkg::ST_OK;
          el          <= el_sample;
        end else begin
          if (bad_kind || gen_bad || val_bad) item_status <= eae_pkg::ST_REJECTED;
          else if (t_early) item_status <= eae_pkg::ST_ORDER;
          else item_status <= eae_pkg::ST_OK;
          el <= is_gate_off ? el_sample : TB'(pulse_ticks);
        end
      end
      eae_pkg::S_HELD: begin
        dec_mode <= !in_attack;
        held     <= sus;
      end
      eae_pkg::S_HDIV:
        if (drsp.done) held <= dec_mode ? eae_pkg::ONE_LEVEL - drsp.q : drsp.q;
      eae_pkg::S_HMUL:
        if (goal_sample) item_level <= prod[eae_pkg::FRAC_BITS +: LW];
      eae_pkg::S_RMUL: ar <= prod[eae_pkg::FRAC_BITS +: LW];
      eae_pkg::S_RDIV: if (drsp.done) item_level <= drsp.q;
      eae_pkg::S_DONE: begin
        out_data.level  <= item_level;
        out_data.status <= item_status;
      end
      default: ;
    endcase
  end

  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == eae_pkg::S_IDLE) else $error("result pending while busy");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == eae_pkg::S_HDIV || state == eae_pkg::S_RDIV))
    else $error("divider result outside a wait state");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != eae_pkg::ST_OK) |-> out_data.level == '0)
    else $error("error beat with nonzero level");
  a_decode: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == eae_pkg::S_DECODE) else $error("beat not decoded");
endmodule
